FILE: rtl/core/pct_pkg.sv
// Shared types and constants for the partitioned countdown timers.
// Used by pct_update and partitioned_countdown_timers; no dependencies.
`default_nettype none

package pct_pkg;

  localparam int MaxParts = 16;
  localparam int PartW    = 4;
  localparam int TimeW    = 31;
  localparam int RemW     = 32;
  localparam int CfgW     = 5;
  localparam int InDataW  = 72;   // 67 payload bits padded to bytes
  localparam int OutDataW = 104;  // 99 payload bits padded to bytes

  localparam logic [CfgW-1:0] PartsReset = CfgW'(1);
  localparam logic [CfgW-1:0] PartsMax   = CfgW'(MaxParts);

  typedef enum logic {
    KindCheck = 1'b0,
    KindSet   = 1'b1
  } kind_e;

  typedef logic [TimeW-1:0] time_t;

  // One timer entry as held in the entry memory.
  typedef struct packed {
    time_t                  base;
    time_t                  last;
    logic signed [RemW-1:0] left;
    logic                   armed;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    kind_e            kind;
    logic [PartW-1:0] part;
    time_t            now;
    logic             holding;
    time_t            deadline;
  } item_t;

  typedef struct packed {
    logic                   expired;
    logic                   ignored;
    logic                   run_time_valid;
    time_t                  run_time;
    logic                   state_time_valid;
    time_t                  state_time;
    logic                   remaining_valid;
    logic signed [RemW-1:0] remaining;
  } result_t;

endpackage : pct_pkg

`default_nettype wire

FILE: rtl/core/pct_update.sv
// Next-entry and result logic for one timer transfer.
// Depends on pct_pkg.
`default_nettype none

module pct_update (
  input  pct_pkg::item_t   item_i,
  input  logic             in_range_i,
  input  pct_pkg::time_t   run_base_i,
  input  pct_pkg::entry_t  entry_i,
  output pct_pkg::entry_t  entry_o,
  output pct_pkg::result_t result_o
);
  import pct_pkg::*;

  logic [RemW-1:0] dt;
  logic [RemW:0]   cnt;
  logic [RemW-1:0] set_left;
  time_t           elapsed;
  logic            cnt_over;
  logic            cnt_done;

  // signed time step since last check
  assign dt       = {1'b0, item_i.now} - {1'b0, entry_i.last};
  assign cnt      = {entry_i.left[RemW-1], entry_i.left} - {dt[RemW-1], dt};
  assign cnt_over = !cnt[RemW] && cnt[RemW-1];
  assign cnt_done = cnt[RemW] || (cnt == '0);
  assign elapsed  = entry_i.last - entry_i.base;
  assign set_left = {1'b0, item_i.deadline} - {1'b0, elapsed};

  always_comb begin
    entry_o  = entry_i;
    result_o = '0;
    if (!in_range_i) begin
      result_o.ignored = 1'b1;
    end else begin
      unique case (item_i.kind)
        KindSet: begin
          result_o.remaining_valid = 1'b1;
          if (item_i.deadline == '0) begin
            entry_o.armed = 1'b0;
          end else begin
            entry_o.left       = set_left;
            entry_o.armed      = 1'b1;
            result_o.remaining = set_left;
          end
        end
        KindCheck: begin
          if (item_i.now != entry_i.last) begin
            result_o.run_time_valid = 1'b1;
            result_o.run_time       = item_i.now - run_base_i;
            entry_o.last            = item_i.now;
            if (item_i.holding) begin
              // freeze state time: base moves with the clock
              entry_o.base = entry_i.base + dt[TimeW-1:0];
            end else begin
              result_o.state_time_valid = 1'b1;
              result_o.state_time       = item_i.now - entry_i.base;
              if (entry_i.armed) begin
                priority if (cnt_done) begin
                  entry_o.left     = '0;
                  result_o.expired = 1'b1;
                end else if (cnt_over) begin
                  entry_o.left             = {1'b0, {(RemW-1){1'b1}}};
                  result_o.remaining_valid = 1'b1;
                  result_o.remaining       = {1'b0, {(RemW-1){1'b1}}};
                end else begin
                  entry_o.left             = cnt[RemW-1:0];
                  result_o.remaining_valid = 1'b1;
                  result_o.remaining       = cnt[RemW-1:0];
                end
              end
            end
          end
        end
        default: begin
          entry_o = entry_i;
        end
      endcase
    end
  end

endmodule : pct_update

`default_nettype wire

FILE: rtl/core/partitioned_countdown_timers.sv
// Top level of the partitioned countdown timers: entry memory, control, ports.
// Depends on pct_pkg and pct_update.
`default_nettype none

// Up to sixteen countdown timers, one per partition, share a single entry
// memory holding base time, last-check time, time left and the armed flag.
// Each input transfer is either a time check (tuser = 0) or a new deadline
// (tuser = 1) for one partition. The entry is read into a register when the
// transfer is accepted and is updated and written back once the output
// register is free; no new item is accepted before that write-back, a limit
// set by the read-then-write-back of the single memory port. The result sits
// in an output register, so the next item is accepted while it waits; the
// update of that next item holds until the result has been taken. Exactly one
// result transfer follows every input transfer. Items for a partition at or
// above partitions_in_use (clamped to 16) leave all state alone and return
// only the ignored flag. The first in-range check starts the run: its time
// stamp becomes the run base and the base and last-check time of every
// partition then in use, applied lazily per entry through a flag bit. Entries
// never written read as zero through per-entry valid bits, so no clearing
// pass follows reset. The user must write partitions_in_use through cfg_we_i
// only while the block is idle; the block itself does not enforce this.
module partitioned_countdown_timers (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: partitions_in_use
  input  logic                         cfg_we_i,
  input  logic [pct_pkg::CfgW-1:0]     cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata, lsb up: partition[3:0], now[34:4], holding[35], deadline[66:36], zero pad
  input  logic [pct_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: kind (0 = check, 1 = set)
  input  logic                         s_axis_tuser,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata, lsb up: expired[0], ignored[1], run_time_valid[2], run_time[33:3],
  // state_time_valid[34], state_time[65:35], remaining_valid[66],
  // remaining[98:67], zero pad
  output logic [pct_pkg::OutDataW-1:0] m_axis_tdata
);
  import pct_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CfgW-1:0]   parts_q;
  logic [CfgW-1:0]   parts_eff;
  logic              started_q;
  time_t             run_base_q;
  logic [MaxParts-1:0] vld_q;    // entry has been written
  logic [MaxParts-1:0] fresh_q;  // entry takes run base for base and last
  logic [MaxParts-1:0] fresh_d;
  item_t             item_q;
  item_t             in_item;
  logic [EntryW-1:0] mem [MaxParts];
  logic [EntryW-1:0] rdata_q;
  entry_t            entry_raw;
  entry_t            entry_res;
  entry_t            entry_new;
  result_t           res;
  logic              in_xfer;
  logic              exec;
  logic              in_range;
  logic              start_now;
  time_t             run_base_eff;
  logic              out_vld_q;
  result_t           out_q;

  // input unpacking
  assign in_item.kind     = kind_e'(s_axis_tuser);
  assign in_item.part     = s_axis_tdata[3:0];
  assign in_item.now      = s_axis_tdata[34:4];
  assign in_item.holding  = s_axis_tdata[35];
  assign in_item.deadline = s_axis_tdata[66:36];

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign exec          = (state_q == StExec) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_xfer) state_d = StExec;
      StExec: if (exec) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // partition range check against the clamped register
  assign parts_eff = (parts_q > PartsMax) ? PartsMax : parts_q;
  assign in_range  = {1'b0, item_q.part} < parts_eff;
  assign start_now = in_range && (item_q.kind == KindCheck) && !started_q;
  assign run_base_eff = start_now ? item_q.now : run_base_q;

  // resolve the entry: unwritten reads as zero, pending start overrides times
  assign entry_raw = vld_q[item_q.part] ? entry_t'(rdata_q) : '0;
  always_comb begin
    entry_res = entry_raw;
    if (start_now || fresh_q[item_q.part]) begin
      entry_res.base = run_base_eff;
      entry_res.last = run_base_eff;
    end
  end

  pct_update u_update (
    .item_i     (item_q),
    .in_range_i (in_range),
    .run_base_i (run_base_eff),
    .entry_i    (entry_res),
    .entry_o    (entry_new),
    .result_o   (res)
  );

  // pending start flags: set for every partition in use at run start;
  // write-back holds resolved times, so the entry's own flag is cleared
  always_comb begin
    fresh_d = fresh_q;
    if (exec && start_now) begin
      for (int i = 0; i < MaxParts; i++) begin
        if (CfgW'(i) < parts_eff) fresh_d[i] = 1'b1;
      end
    end
    if (exec && in_range) begin
      fresh_d[item_q.part] = 1'b0;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (exec && in_range) begin
      mem[item_q.part] <= entry_new;
    end
    if (in_xfer) begin
      rdata_q <= mem[in_item.part];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_item;
    end
    if (exec) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      parts_q    <= PartsReset;
      started_q  <= 1'b0;
      run_base_q <= '0;
      vld_q      <= '0;
      fresh_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fresh_q <= fresh_d;
      if (cfg_we_i) begin
        parts_q <= cfg_wdata_i;
      end
      if (exec) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (exec && start_now) begin
        started_q  <= 1'b1;
        run_base_q <= item_q.now;
      end
      if (exec && in_range) begin
        vld_q[item_q.part] <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {
    {(OutDataW-99){1'b0}},
    out_q.remaining,
    out_q.remaining_valid,
    out_q.state_time,
    out_q.state_time_valid,
    out_q.run_time,
    out_q.run_time_valid,
    out_q.ignored,
    out_q.expired
  };

  // interlock: no back-to-back input transfers
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input transfer accepted while an entry update is pending");

  // pending start flags exist only once the run has started
  a_fresh_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q != '0) |-> started_q)
    else $error("start flag set before run start");

  // run base is latched once
  a_run_base_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(started_q) && started_q) |-> $stable(run_base_q))
    else $error("run base changed after run start");

endmodule : partitioned_countdown_timers

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for partitioned_countdown_timers: directed and random stream traffic.
// Depends on pct_pkg and the block's RTL; its predictor models the timer table independently.

module tb;
  import pct_pkg::*;

  localparam time_t MaxTime = '1;

  // ports
  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // tdata, lsb up: partition[3:0], now[34:4], holding[35], deadline[66:36], zero pad
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // tuser: kind (0 = check, 1 = set)
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // tdata, lsb up: expired, ignored, run_time_valid, run_time, state_time_valid,
  // state_time, remaining_valid, remaining, zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  partitioned_countdown_timers dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor copy of the timer table and the partition count.
  logic [CfgW-1:0]        parts_cfg = PartsReset;
  bit                     run_started = 1'b0;
  time_t                  run_base_t  = '0;
  time_t                  base_t [MaxParts];
  time_t                  last_t [MaxParts];
  logic signed [RemW-1:0] left_t [MaxParts];
  bit                     armed_t[MaxParts];

  result_t     timer_results[$];   // expected readings, oldest first
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  bit          steady_flow  = 1'b0; // no gaps on either side while set
  time_t       wall         = '0;   // stimulus clock for well-formed check stamps

  initial begin
    for (int i = 0; i < MaxParts; i++) begin
      base_t[i]  = '0;
      last_t[i]  = '0;
      left_t[i]  = '0;
      armed_t[i] = 1'b0;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: worst legal run is well under a tenth of this.
  initial begin : watchdog
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int active_parts();
    return (parts_cfg > MaxParts) ? MaxParts : int'(parts_cfg);
  endfunction

  // Work out the reading for one accepted item and advance the table.
  function automatic result_t predict_timer(input item_t it);
    result_t r;
    int      n;
    int      p;
    time_t   elapsed;
    longint  dt;
    longint  v;
    r = '0;
    n = active_parts();
    p = int'(it.part);
    if (p >= n) begin
      r.ignored = 1'b1;
      return r;
    end
    if (it.kind == KindSet) begin
      r.remaining_valid = 1'b1;
      if (it.deadline == '0) begin
        armed_t[p]  = 1'b0;
        r.remaining = '0;
      end else begin
        elapsed     = last_t[p] - base_t[p];
        v           = longint'(it.deadline) - longint'(elapsed);
        left_t[p]   = v[RemW-1:0];
        armed_t[p]  = 1'b1;
        r.remaining = left_t[p];
      end
      return r;
    end
    // first in-range check starts the run for every partition then in use
    if (!run_started) begin
      run_started = 1'b1;
      run_base_t  = it.now;
      for (int i = 0; i < n; i++) begin
        base_t[i] = it.now;
        last_t[i] = it.now;
      end
    end
    if (it.now != last_t[p]) begin
      dt               = longint'(it.now) - longint'(last_t[p]);
      r.run_time_valid = 1'b1;
      r.run_time       = it.now - run_base_t;
      last_t[p]        = it.now;
      if (it.holding) begin
        base_t[p] = time_t'(longint'(base_t[p]) + dt);
      end else begin
        r.state_time_valid = 1'b1;
        r.state_time       = it.now - base_t[p];
        if (armed_t[p]) begin
          v = longint'(left_t[p]) - dt;
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v <= 0) begin
            left_t[p] = '0;
            r.expired = 1'b1;  // stays armed, so a later forward stamp that is not holding expires again
          end else begin
            left_t[p]         = v[RemW-1:0];
            r.remaining_valid = 1'b1;
            r.remaining       = left_t[p];
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] mismatch on result %0d, %s: got %0h, want %0h",
             $time, results_seen, what, got, want);
  endtask

  // Send one item; the expectation is queued when the transfer happens.
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, it.deadline, it.holding, it.now, it.part};
    s_axis_tuser  <= it.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    timer_results.push_back(predict_timer(it));
  endtask

  // Result side: random stall before each transfer.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (timer_results.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata[63:0], '0);
      end else begin
        e = timer_results.pop_front();
        if (m_axis_tdata[0] !== e.expired)
          report_mismatch("expired", 64'(m_axis_tdata[0]), 64'(e.expired));
        if (m_axis_tdata[1] !== e.ignored)
          report_mismatch("ignored", 64'(m_axis_tdata[1]), 64'(e.ignored));
        if (m_axis_tdata[2] !== e.run_time_valid)
          report_mismatch("run_time_valid", 64'(m_axis_tdata[2]),
                          64'(e.run_time_valid));
        if (m_axis_tdata[33:3] !== e.run_time)
          report_mismatch("run_time", 64'(m_axis_tdata[33:3]), 64'(e.run_time));
        if (m_axis_tdata[34] !== e.state_time_valid)
          report_mismatch("state_time_valid", 64'(m_axis_tdata[34]),
                          64'(e.state_time_valid));
        if (m_axis_tdata[65:35] !== e.state_time)
          report_mismatch("state_time", 64'(m_axis_tdata[65:35]), 64'(e.state_time));
        if (m_axis_tdata[66] !== e.remaining_valid)
          report_mismatch("remaining_valid", 64'(m_axis_tdata[66]),
                          64'(e.remaining_valid));
        if (m_axis_tdata[98:67] !== e.remaining)
          report_mismatch("remaining", 64'(m_axis_tdata[98:67]),
                          64'(unsigned'(e.remaining)));
      end
    end
  end

  // Register writes only once every expected result has come back.
  task automatic write_parts(input logic [CfgW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (timer_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    parts_cfg    = value;
  endtask

  function automatic item_t make_item(input kind_e k, input int p, input time_t now,
                                      input bit hold, input time_t dl);
    item_t it;
    it.kind     = k;
    it.part     = PartW'(p);
    it.now      = now;
    it.holding  = hold;
    it.deadline = dl;
    return it;
  endfunction

  // Mostly well-formed traffic: in-range partitions, stamps that creep forward,
  // deadlines a little past the elapsed state time; the rest is noise.
  function automatic item_t random_item();
    item_t       it;
    int          n;
    int unsigned sel;
    time_t       elapsed;
    n           = active_parts();
    it.part     = (n > 0 && $urandom_range(0, 9) != 0) ? PartW'($urandom_range(0, n - 1))
                                                        : PartW'($urandom_range(0, 15));
    it.kind     = ($urandom_range(0, 3) == 0) ? KindSet : KindCheck;
    it.now      = time_t'($urandom);
    it.holding  = ($urandom_range(0, 5) == 0);
    it.deadline = time_t'($urandom);
    if (it.kind == KindCheck) begin
      wall = wall + time_t'($urandom_range(0, 6));
      sel  = $urandom_range(0, 99);
      if (sel < 80)      it.now = wall;
      else if (sel < 90) it.now = wall - time_t'($urandom_range(1, 50));
      else if (sel < 95) it.now = last_t[it.part];   // same stamp again
      // otherwise keep the fully random stamp
    end else begin
      sel     = $urandom_range(0, 99);
      elapsed = last_t[it.part] - base_t[it.part];
      if (sel < 15)      it.deadline = '0;
      else if (sel < 85) it.deadline = elapsed + time_t'($urandom_range(1, 30));
    end
    return it;
  endfunction

  task automatic run_phase(input int unsigned target);
    item_t       it;
    int unsigned sent;
    sent = 0;
    while (sent < target) begin
      it = random_item();
      if (int'(it.part) < active_parts()) sent++;
      send_item(it);
    end
  endtask

  // Hand-picked corners with the reset partition count of one, then sixteen.
  task automatic test_directed_cases();
    send_item(make_item(KindSet,   0,  '0,      1'b0, MaxTime)); // armed before run start
    send_item(make_item(KindCheck, 1,  31'd50,  1'b0, '0));      // out of range
    send_item(make_item(KindSet,   15, MaxTime, 1'b1, MaxTime)); // out of range, all ones
    send_item(make_item(KindCheck, 0,  31'd100, 1'b0, '0));      // starts the run
    send_item(make_item(KindCheck, 0,  31'd100, 1'b0, '0));      // same stamp
    send_item(make_item(KindCheck, 0,  31'd90,  1'b0, '0));      // backwards, saturates
    send_item(make_item(KindCheck, 0,  MaxTime, 1'b1, '0));      // hold shifts base
    send_item(make_item(KindCheck, 0,  '0,      1'b0, '0));      // big step back
    send_item(make_item(KindSet,   0,  '0,      1'b0, 31'd3));
    send_item(make_item(KindCheck, 0,  31'd1,   1'b0, '0));
    send_item(make_item(KindCheck, 0,  31'd5,   1'b0, '0));      // expiry
    send_item(make_item(KindCheck, 0,  31'd6,   1'b0, '0));      // expires again
    send_item(make_item(KindSet,   0,  '0,      1'b0, '0));      // disarm
    send_item(make_item(KindCheck, 0,  31'd9,   1'b0, '0));      // no remaining
    write_parts(PartsMax);
    send_item(make_item(KindSet,   15, '0,      1'b0, 31'd1));
    send_item(make_item(KindCheck, 15, 31'd20,  1'b0, '0));      // partition not started
    send_item(make_item(KindSet,   7,  '0,      1'b0, 31'd40));
    send_item(make_item(KindCheck, 7,  31'd30,  1'b1, '0));      // holding
    send_item(make_item(KindCheck, 7,  31'd35,  1'b0, '0));
    send_item(make_item(KindCheck, 7,  31'd80,  1'b0, '0));      // counts to zero
  endtask

  // Count of zero ignores everything; counts above sixteen clamp.
  task automatic test_partition_limits();
    write_parts('0);
    repeat (8) send_item(random_item());
    write_parts('1);
    send_item(make_item(KindCheck, 15, 31'd200, 1'b0, '0));
    send_item(make_item(KindSet,   15, '0,      1'b0, 31'd500));
    send_item(make_item(KindCheck, 0,  31'd210, 1'b0, '0));
    write_parts(CfgW'(17));
    send_item(make_item(KindCheck, 15, 31'd230, 1'b0, '0));
  endtask

  task automatic test_random_traffic();
    wall = 31'd1000;
    write_parts(PartsMax);
    run_phase(160);
    write_parts(PartsReset);
    run_phase(100);
    write_parts(CfgW'(8));
    wall = time_t'($urandom);
    run_phase(160);
    write_parts(CfgW'($urandom_range(2, 15)));
    run_phase(140);
    write_parts('1);
    wall = MaxTime - 31'd200;   // stamps wrap through zero
    run_phase(160);
    steady_flow = 1'b1;
    write_parts(PartsMax);
    run_phase(140);
    steady_flow = 1'b0;
    write_parts(CfgW'(3));
    run_phase(100);
    write_parts(CfgW'($urandom_range(17, 30)));
    run_phase(140);
  endtask

  initial begin : main_sequence
    int unsigned k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_partition_limits();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    k = 0;
    while (timer_results.size() != 0 && k < 2000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (8) @(posedge clk_i);
    if (timer_results.size() != 0)
      report_mismatch("results never arrived", 64'(unsigned'(timer_results.size())), '0);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pct_pkg.sv
rtl/core/pct_update.sv
rtl/core/partitioned_countdown_timers.sv
test/tb.sv
